// ===== design/ism_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants of the integer stack machine.
// ----------------------------------------------------------------------------
package ism_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W = 31;
    localparam int ACT_W = 4;
    localparam logic signed [63:0] MAG_LIMIT = 64'sd1000000000;

    localparam logic [ACT_W-1:0] ACT_START = 4'd0;
    localparam logic [ACT_W-1:0] ACT_NUM = 4'd1;
    localparam logic [ACT_W-1:0] ACT_POP = 4'd2;
    localparam logic [ACT_W-1:0] ACT_INV = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DUP = 4'd4;
    localparam logic [ACT_W-1:0] ACT_SWP = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ADD = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SUB = 4'd7;
    localparam logic [ACT_W-1:0] ACT_MUL = 4'd8;
    localparam logic [ACT_W-1:0] ACT_DIV = 4'd9;
    localparam logic [ACT_W-1:0] ACT_MOD = 4'd10;
    localparam logic [ACT_W-1:0] ACT_END = 4'd11;

    typedef enum logic [2:0] {
        DP_NONE = 3'd0,
        DP_RD_B = 3'd1,
        DP_RD_A = 3'd2,
        DP_ALU = 3'd3,
        DP_DIV = 3'd4
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic [ACT_W-1:0] action;
        logic [ADDR_W-1:0] addr;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_zero;
        logic mag_err;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== design/integer_stack_machine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_stack_machine_core
// Stack calculator running a stream of instruction words.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_        in         action, operand_value
// m_        out        result on END: error, result_value
//
// START, NUM, POP, words that fail at once and skipped words finish in S_IDLE;
// INV and DUP read one word and SWP, ADD, SUB and MUL two, each paced by the single
// stack RAM port. DIV and MOD run the one-bit-per-cycle divider; a zero divisor
// ends them before the first divide step.
// END holds off new words until m_tready takes the result.
// Reset is synchronous and active low; the stack RAM needs no clearing.
// ----------------------------------------------------------------------------
module integer_stack_machine_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [39:0]  s_tdata,   // [3:0] action, [34:4] operand_value
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata    // [0] error, [31:1] result_value
);
    ism_pkg::dp_cmd_t cmd;
    ism_pkg::dp_stat_t stat;
    logic wr_en, wr_sel_operand, wr_sel_a, wr_sel_b;
    logic signed [ism_pkg::VAL_W-1:0] rd_value, m_value;
    logic m_error;

    ism_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_action(s_tdata[3:0]),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_error(m_error), .m_value(m_value),
        .rd_value(rd_value), .stat(stat), .cmd(cmd), .wr_en(wr_en),
        .wr_sel_operand(wr_sel_operand), .wr_sel_a(wr_sel_a), .wr_sel_b(wr_sel_b)
    );

    ism_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .wr_en(wr_en),
        .wr_sel_operand(wr_sel_operand), .wr_sel_a(wr_sel_a), .wr_sel_b(wr_sel_b),
        .operand(s_tdata[34:4]), .stat(stat), .res_out(rd_value)
    );

    assign m_tdata = {m_value, m_error};
endmodule
`default_nettype wire

// ===== design/ism_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ism_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] addr,
    input  wire [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/ism_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_datapath
// Stack memory, operand registers, add/sub/mul unit and serial divider.
// ----------------------------------------------------------------------------
module ism_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire ism_pkg::dp_cmd_t              cmd,
    input  wire                                wr_en,
    input  wire                                wr_sel_operand,
    input  wire                                wr_sel_a,
    input  wire                                wr_sel_b,
    input  wire signed [ism_pkg::VAL_W-1:0]    operand,
    output ism_pkg::dp_stat_t                  stat,
    output logic signed [ism_pkg::VAL_W-1:0]   res_out
);
    localparam int W = ism_pkg::VAL_W;
    logic [W-1:0] rdata;
    logic signed [W-1:0] a_reg, b_reg, r_reg;
    logic signed [W-1:0] a_next, b_next, r_next;
    logic mag_reg, mag_next;
    logic signed [W-1:0] wdata;
    logic [4:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [W-1:0] quo_reg, quo_next, dvd_reg, dvd_next;
    logic [W:0] rem_reg, rem_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic done_reg, done_next;
    logic signed [63:0] wide;
    logic [W:0] trial;

    always_comb begin
        wdata = r_reg;
        if (wr_sel_operand) wdata = operand;
        else if (wr_sel_a) wdata = a_reg;
        else if (wr_sel_b) wdata = b_reg;
    end

    ism_ram #(.WIDTH(W), .DEPTH(ism_pkg::STACK_DEPTH)) u_ram (
        .aclk(aclk), .we(wr_en), .addr(cmd.addr), .wdata(wdata), .rdata(rdata)
    );

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        mag_next = mag_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        quo_next = quo_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        done_next = 1'b0;
        wide = 64'sd0;
        trial = '0;
        unique case (cmd.op)
            ism_pkg::DP_RD_B: b_next = rdata;
            ism_pkg::DP_RD_A: a_next = rdata;
            ism_pkg::DP_ALU: begin
                priority case (cmd.action)
                    ism_pkg::ACT_ADD: wide = 64'(a_reg) + 64'(b_reg);
                    ism_pkg::ACT_SUB: wide = 64'(a_reg) - 64'(b_reg);
                    ism_pkg::ACT_MUL: wide = 64'(a_reg) * 64'(b_reg);
                    ism_pkg::ACT_INV: wide = -64'(b_reg);
                    default: wide = 64'(b_reg);
                endcase
                r_next = wide[W-1:0];
                mag_next = (wide > ism_pkg::MAG_LIMIT) || (wide < -ism_pkg::MAG_LIMIT);
            end
            ism_pkg::DP_DIV: begin
                if (!busy_reg) begin
                    busy_next = 1'b1;
                    cnt_next = 5'(W - 1);
                    dvd_next = a_reg[W-1] ? W'(-a_reg) : a_reg;
                    dvs_next = b_reg[W-1] ? W'(-b_reg) : b_reg;
                    rem_next = '0;
                    quo_next = '0;
                end else begin
                    trial = {rem_reg[W-1:0], dvd_reg[W-1]};
                    dvd_next = {dvd_reg[W-2:0], 1'b0};
                    if (trial >= {1'b0, dvs_reg}) begin
                        rem_next = trial - {1'b0, dvs_reg};
                        quo_next = {quo_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = trial;
                        quo_next = {quo_reg[W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        if (cmd.action == ism_pkg::ACT_DIV) begin
                            r_next = (a_reg[W-1] ^ b_reg[W-1]) ? W'(-quo_next) : quo_next;
                        end else begin
                            r_next = a_reg[W-1] ? W'(-rem_next[W-1:0])
                                                : rem_next[W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        mag_reg <= mag_next;
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.div_done = done_reg;
    assign stat.div_zero = (b_reg == '0);
    assign stat.mag_err = mag_reg;
    assign res_out = rdata;
endmodule
`default_nettype wire

// ===== design/ism_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_controller
// Sequencer: decodes each word, steps the datapath and emits results.
// ----------------------------------------------------------------------------
module ism_controller (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [ism_pkg::ACT_W-1:0]         s_action,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic                             m_error,
    output logic signed [ism_pkg::VAL_W-1:0] m_value,
    input  wire signed [ism_pkg::VAL_W-1:0]  rd_value,
    input  wire ism_pkg::dp_stat_t           stat,
    output ism_pkg::dp_cmd_t                 cmd,
    output logic                             wr_en,
    output logic                             wr_sel_operand,
    output logic                             wr_sel_a,
    output logic                             wr_sel_b
);
    localparam int CW = ism_pkg::CNT_W;
    localparam int AW = ism_pkg::ADDR_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_RDB  = 8'b00000010,
        S_RDA  = 8'b00000100,
        S_LATA = 8'b00001000,
        S_ALU  = 8'b00010000,
        S_DIV  = 8'b00100000,
        S_WR   = 8'b01000000,
        S_END  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic err_reg, err_next;
    logic [ism_pkg::ACT_W-1:0] act_reg, act_next;
    logic out_v_reg, out_v_next, out_e_reg, out_e_next;
    logic signed [ism_pkg::VAL_W-1:0] out_d_reg, out_d_next;
    logic acc, full;

    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign acc = s_tvalid && s_tready;
    assign full = (cnt_reg == CW'(ism_pkg::STACK_DEPTH));

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        act_next = act_reg;
        out_v_next = out_v_reg && !m_tready;
        out_e_next = out_e_reg;
        out_d_next = out_d_reg;
        cmd.op = ism_pkg::DP_NONE;
        cmd.action = act_reg;
        cmd.addr = AW'(cnt_reg - CW'(1));
        wr_en = 1'b0;
        wr_sel_operand = 1'b0;
        wr_sel_a = 1'b0;
        wr_sel_b = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    act_next = s_action;
                    priority if (s_action == ism_pkg::ACT_START) begin
                        cmd.addr = '0;
                        wr_en = 1'b1;
                        wr_sel_operand = 1'b1;
                        cnt_next = CW'(1);
                        err_next = 1'b0;
                    end else if (s_action == ism_pkg::ACT_END) begin
                        cmd.addr = '0;
                        state_next = S_END;
                    end else if (s_action > ism_pkg::ACT_END || err_reg) begin
                    end else if (s_action == ism_pkg::ACT_NUM) begin
                        cmd.addr = AW'(cnt_reg);
                        if (full) err_next = 1'b1;
                        else begin
                            wr_en = 1'b1;
                            wr_sel_operand = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end else if (s_action <= ism_pkg::ACT_DUP) begin
                        if (cnt_reg == '0) err_next = 1'b1;
                        else if (s_action == ism_pkg::ACT_POP) cnt_next = cnt_reg - CW'(1);
                        else state_next = S_RDB;
                    end else begin
                        if (cnt_reg < CW'(2)) err_next = 1'b1;
                        else state_next = S_RDB;
                    end
                end
            end
            S_RDB: begin
                cmd.op = ism_pkg::DP_RD_B;
                cmd.addr = AW'(cnt_reg - CW'(2));
                state_next = (act_reg <= ism_pkg::ACT_DUP) ? S_ALU : S_RDA;
            end
            S_RDA: begin
                cmd.op = ism_pkg::DP_RD_A;
                state_next = S_LATA;
            end
            S_LATA: begin
                if (act_reg == ism_pkg::ACT_SWP) begin
                    wr_en = 1'b1;
                    wr_sel_a = 1'b1;
                    state_next = S_WR;
                end else if (act_reg >= ism_pkg::ACT_DIV) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_ALU;
                end
            end
            S_ALU: begin
                cmd.op = ism_pkg::DP_ALU;
                state_next = S_WR;
            end
            S_DIV: begin
                if (stat.div_zero) begin
                    err_next = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.div_done) begin
                    state_next = S_WR;
                end else begin
                    cmd.op = ism_pkg::DP_DIV;
                end
            end
            S_WR: begin
                state_next = S_IDLE;
                priority if (act_reg == ism_pkg::ACT_SWP) begin
                    cmd.addr = AW'(cnt_reg - CW'(2));
                    wr_en = 1'b1;
                    wr_sel_b = 1'b1;
                end else if (act_reg == ism_pkg::ACT_DUP) begin
                    cmd.addr = AW'(cnt_reg);
                    if (full) err_next = 1'b1;
                    else begin
                        wr_en = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end else if (act_reg == ism_pkg::ACT_INV) begin
                    wr_en = 1'b1;
                end else if (act_reg <= ism_pkg::ACT_MUL && stat.mag_err) begin
                    err_next = 1'b1;
                end else begin
                    cmd.addr = AW'(cnt_reg - CW'(2));
                    wr_en = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_END: begin
                out_v_next = 1'b1;
                out_e_next = err_reg || (cnt_reg != CW'(1));
                out_d_next = (err_reg || (cnt_reg != CW'(1))) ? '0 : rd_value;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            err_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            out_v_reg <= out_v_next;
        end
        act_reg <= act_next;
        out_e_reg <= out_e_next;
        out_d_reg <= out_d_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_error = out_e_reg;
    assign m_value = out_d_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(ism_pkg::STACK_DEPTH)) else $error("stack count overflow");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_error) |-> (m_value == '0)) else $error("error result not zero");
    a_end_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_END) |=> m_tvalid) else $error("end gave no result");
endmodule
`default_nettype wire
